### design/usg_pkg.sv
// ---------------------------------------------------------------------------
// usg_pkg
// Shared constants, types and tables for the UV-sphere mesh generator.
// ---------------------------------------------------------------------------
package usg_pkg;

    localparam int MaxSegments = 256;
    localparam int MaxRings    = 256;
    localparam int CordicSteps = 16;
    localparam int MinCount    = 3;

    localparam int CntW  = 9;
    localparam int IdxW  = 16;
    localparam int AngW  = 16;
    localparam int RadW  = 16;
    localparam int PosW  = 17;
    localparam int StepW = $clog2(CordicSteps + 1);

    // Register indexes
    localparam logic [2:0] RegSegCount = 3'd0;
    localparam logic [2:0] RegRingCount = 3'd1;
    localparam logic [2:0] RegRadius   = 3'd2;
    localparam logic [2:0] RegRingStep = 3'd3;
    localparam logic [2:0] RegSegStep  = 3'd4;

    localparam logic signed [35:0] CordicGain = 36'sd652032874;
    localparam logic signed [35:0] PosMax = 36'sd65535;
    localparam logic signed [35:0] PosMin = -36'sd65536;

    // Walk phases
    typedef enum logic [2:0] {
        PH_RING    = 3'd0,
        PH_BAND_A  = 3'd1,
        PH_BAND_B  = 3'd2,
        PH_TOP_VTX = 3'd3,
        PH_TOP_FAN = 3'd4,
        PH_BOT_VTX = 3'd5,
        PH_BOT_FAN = 3'd6
    } t_phase;

    // Datapath command from the controller
    typedef struct packed {
        logic start;     // accept item: compute and advance
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;      // result register loaded this cycle
    } t_status;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### design/usg_ctrl.sv
// ---------------------------------------------------------------------------
// usg_ctrl
// Handshake controller: accepts an item, runs the datapath, holds the result.
// ---------------------------------------------------------------------------
module usg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  logic            i_restart,
    output usg_pkg::t_cmd   o_cmd,
    input  usg_pkg::t_status i_status
);
    import usg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // Accept when nothing is in flight; the result register may still be
    // waiting, so allow accept in S_OUT only when it is taken this cycle.
    assign accept  = i_valid && !o_stall;
    assign o_stall = !((r_state == S_IDLE) || (r_state == S_OUT && !i_stall));
    assign o_valid = (r_state == S_OUT);
    assign o_cmd.start   = accept;
    assign o_cmd.restart = i_restart;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_RUN;
            S_RUN:  if (i_status.done) n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) n_state = accept ? S_RUN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

### design/usg_datapath.sv
// ---------------------------------------------------------------------------
// usg_datapath
// Walk state, CORDIC unit, scaling multiplies and the result register.
// ---------------------------------------------------------------------------
module usg_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  usg_pkg::t_cmd                 i_cmd,
    output usg_pkg::t_status              o_status,
    input  logic [usg_pkg::CntW-1:0]      i_segment_count,
    input  logic [usg_pkg::CntW-1:0]      i_ring_count,
    input  logic [usg_pkg::RadW-1:0]      i_sphere_radius,
    input  logic [usg_pkg::AngW-1:0]      i_ring_angle_step,
    input  logic [usg_pkg::AngW-1:0]      i_segment_angle_step,
    output logic                          o_kind,
    output logic signed [usg_pkg::PosW-1:0] o_pos_x,
    output logic signed [usg_pkg::PosW-1:0] o_pos_y,
    output logic signed [usg_pkg::PosW-1:0] o_pos_z,
    output logic [usg_pkg::IdxW-1:0]      o_corner_a,
    output logic [usg_pkg::IdxW-1:0]      o_corner_b,
    output logic [usg_pkg::IdxW-1:0]      o_corner_c,
    output logic                          o_mesh_end
);
    import usg_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_COR  = 5'b00010,
        D_MUL1 = 5'b00100,
        D_MUL2 = 5'b01000,
        D_DONE = 5'b10000
    } t_dstate;

    t_dstate r_ds;

    // walk state
    t_phase           r_phase;
    logic [7:0]       r_ring, r_around, r_band;
    logic [AngW-1:0]  r_lat, r_lon;

    // clamped counts
    logic [CntW-1:0] segs, rings;
    always_comb begin
        segs  = (i_segment_count < CntW'(MinCount)) ? CntW'(MinCount) :
                (i_segment_count > CntW'(MaxSegments)) ? CntW'(MaxSegments) : i_segment_count;
        rings = (i_ring_count < CntW'(MinCount)) ? CntW'(MinCount) :
                (i_ring_count > CntW'(MaxRings)) ? CntW'(MaxRings) : i_ring_count;
    end

    // effective walk state after a restart request
    logic       rst_walk;
    t_phase     e_phase;
    logic [7:0] e_ring, e_around, e_band;
    logic [AngW-1:0] e_lat, e_lon;
    always_comb begin
        rst_walk = i_cmd.restart || (r_phase == 3'd7);
        e_phase  = rst_walk ? PH_RING : r_phase;
        e_ring   = rst_walk ? 8'd0 : r_ring;
        e_around = rst_walk ? 8'd0 : r_around;
        e_band   = rst_walk ? 8'd0 : r_band;
        e_lat    = rst_walk ? i_ring_angle_step : r_lat;
        e_lon    = rst_walk ? '0 : r_lon;
    end

    logic [CntW:0]  s1w;
    logic           at_end;
    logic [7:0]     s1;
    logic [IdxW-1:0] top, last, cur, nxt, s16, s116;
    always_comb begin
        s1w    = {2'b0, e_around} + 10'd1;
        at_end = (s1w >= {1'b0, segs});
        s1     = at_end ? 8'd0 : s1w[7:0];
        s16    = {8'd0, e_around};
        s116   = {8'd0, s1};
        top    = IdxW'(({7'd0, rings} - 16'd1) * {7'd0, segs});
        last   = IdxW'(({7'd0, rings} - 16'd2) * {7'd0, segs});
        cur    = IdxW'({8'd0, e_band} * {7'd0, segs});
        nxt    = cur + {7'd0, segs};
    end

    // CORDIC: two rotations (latitude, longitude) in lockstep
    logic signed [35:0] r_xa, r_ya, r_za, r_xb, r_yb, r_zb;
    logic [1:0]         r_qa, r_qb;
    logic [StepW-1:0]   r_it;
    logic signed [35:0] ct, st, cp, sp;
    logic signed [35:0] r_rr, r_y;
    logic signed [52:0] prod_rr, prod_y, prod_x, prod_z;

    function automatic logic signed [35:0] q_c(input logic [1:0] q,
        input logic signed [35:0] x, input logic signed [35:0] y);
        case (q)
            2'd0: q_c = x;
            2'd1: q_c = -y;
            2'd2: q_c = -x;
            default: q_c = y;
        endcase
    endfunction
    function automatic logic signed [35:0] q_s(input logic [1:0] q,
        input logic signed [35:0] x, input logic signed [35:0] y);
        case (q)
            2'd0: q_s = y;
            2'd1: q_s = x;
            2'd2: q_s = -y;
            default: q_s = -x;
        endcase
    endfunction
    function automatic logic signed [PosW-1:0] sat(input logic signed [52:0] p);
        logic signed [52:0] v;
        v = (p + 53'sd536870912) >>> 30;
        if (v > 53'(PosMax)) v = 53'(PosMax);
        if (v < 53'(PosMin)) v = 53'(PosMin);
        return v[PosW-1:0];
    endfunction

    always_comb begin
        ct = q_c(r_qa, r_xa, r_ya);
        st = q_s(r_qa, r_xa, r_ya);
        cp = q_c(r_qb, r_xb, r_yb);
        sp = q_s(r_qb, r_xb, r_yb);
        prod_rr = 53'($signed({1'b0, i_sphere_radius})) * 53'(st);
        prod_y  = 53'($signed({1'b0, i_sphere_radius})) * 53'(ct);
        prod_x  = 53'(r_rr) * 53'(sp);
        prod_z  = 53'(r_rr) * 53'(cp);
    end

    logic signed [35:0] at;
    assign at = 36'($signed({1'b0, atan_turns(5'(r_it))}));

    assign o_status.busy = (r_ds != D_IDLE);
    assign o_status.done = (r_ds == D_DONE) || (i_cmd.start && e_phase != PH_RING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds     <= D_IDLE;
            r_phase  <= PH_RING;
            r_ring   <= '0;
            r_around <= '0;
            r_band   <= '0;
            r_lat    <= AngW'(2048);
            r_lon    <= '0;
        end else begin
            case (r_ds)
                D_IDLE: if (i_cmd.start) begin
                    // default: step walk state
                    r_phase  <= e_phase;
                    r_ring   <= e_ring;
                    r_around <= e_around;
                    r_band   <= e_band;
                    r_lat    <= e_lat;
                    r_lon    <= e_lon;
                    o_kind   <= 1'b1;
                    o_pos_x  <= '0; o_pos_y <= '0; o_pos_z <= '0;
                    o_corner_a <= '0; o_corner_b <= '0; o_corner_c <= '0;
                    o_mesh_end <= 1'b0;
                    case (e_phase)
                        PH_RING: begin
                            r_qa <= e_lat[15:14];
                            r_qb <= e_lon[15:14];
                            r_xa <= CordicGain; r_ya <= '0;
                            r_xb <= CordicGain; r_yb <= '0;
                            r_za <= 36'({e_lat[13:0], 16'd0});
                            r_zb <= 36'({e_lon[13:0], 16'd0});
                            r_it <= '0;
                            r_ds <= D_COR;
                            if (at_end) begin
                                r_around <= '0;
                                r_lon    <= '0;
                                r_lat    <= e_lat + i_ring_angle_step;
                                if ({1'b0, e_ring} + 9'd2 >= rings) begin
                                    r_phase <= PH_BAND_A;
                                    r_band  <= '0;
                                end else r_ring <= e_ring + 8'd1;
                            end else begin
                                r_around <= e_around + 8'd1;
                                r_lon    <= e_lon + i_segment_angle_step;
                            end
                        end
                        PH_BAND_A: begin
                            o_corner_a <= cur + s16;
                            o_corner_b <= nxt + s16;
                            o_corner_c <= nxt + s116;
                            r_phase    <= PH_BAND_B;
                            r_ds       <= D_DONE;
                        end
                        PH_BAND_B: begin
                            o_corner_a <= cur + s16;
                            o_corner_b <= nxt + s116;
                            o_corner_c <= cur + s116;
                            r_phase    <= PH_BAND_A;
                            r_ds       <= D_DONE;
                            if (at_end) begin
                                r_around <= '0;
                                if ({1'b0, e_band} + 9'd3 >= rings) r_phase <= PH_TOP_VTX;
                                else r_band <= e_band + 8'd1;
                            end else r_around <= e_around + 8'd1;
                        end
                        PH_TOP_VTX, PH_BOT_VTX: begin
                            o_kind   <= 1'b0;
                            o_pos_y  <= (e_phase == PH_TOP_VTX) ?
                                        PosW'({1'b0, i_sphere_radius}) :
                                        -PosW'({1'b0, i_sphere_radius});
                            r_around <= '0;
                            r_phase  <= (e_phase == PH_TOP_VTX) ? PH_TOP_FAN : PH_BOT_FAN;
                            r_ds     <= D_DONE;
                        end
                        PH_TOP_FAN: begin
                            o_corner_a <= top;
                            o_corner_b <= s16;
                            o_corner_c <= s116;
                            r_ds       <= D_DONE;
                            if (at_end) begin
                                r_around <= '0;
                                r_phase  <= PH_BOT_VTX;
                            end else r_around <= e_around + 8'd1;
                        end
                        default: begin
                            o_corner_a <= last + s16;
                            o_corner_b <= top + 16'd1;
                            o_corner_c <= last + s116;
                            o_mesh_end <= at_end;
                            r_ds       <= D_DONE;
                            if (at_end) begin
                                r_phase  <= PH_RING;
                                r_ring   <= '0;
                                r_around <= '0;
                                r_band   <= '0;
                                r_lat    <= i_ring_angle_step;
                                r_lon    <= '0;
                            end else r_around <= e_around + 8'd1;
                        end
                    endcase
                end
                D_COR: begin
                    // one micro-rotation per cycle on both angles
                    if (r_za >= 0) begin
                        r_xa <= r_xa - (r_ya >>> r_it); r_ya <= r_ya + (r_xa >>> r_it);
                        r_za <= r_za - at;
                    end else begin
                        r_xa <= r_xa + (r_ya >>> r_it); r_ya <= r_ya - (r_xa >>> r_it);
                        r_za <= r_za + at;
                    end
                    if (r_zb >= 0) begin
                        r_xb <= r_xb - (r_yb >>> r_it); r_yb <= r_yb + (r_xb >>> r_it);
                        r_zb <= r_zb - at;
                    end else begin
                        r_xb <= r_xb + (r_yb >>> r_it); r_yb <= r_yb - (r_xb >>> r_it);
                        r_zb <= r_zb + at;
                    end
                    if (r_it == StepW'(CordicSteps - 1)) r_ds <= D_MUL1;
                    r_it <= r_it + StepW'(1);
                end
                D_MUL1: begin
                    r_rr <= 36'((prod_rr + 53'sd536870912) >>> 30);
                    r_y  <= 36'(sat(prod_y));
                    r_ds <= D_MUL2;
                end
                D_MUL2: begin
                    o_kind  <= 1'b0;
                    o_pos_x <= sat(prod_x);
                    o_pos_y <= r_y[PosW-1:0];
                    o_pos_z <= sat(prod_z);
                    r_ds    <= D_DONE;
                end
                default: r_ds <= i_cmd.start ? D_IDLE : D_IDLE;
            endcase
        end
    end
endmodule

### design/uv_sphere_mesh_generator.sv
// ---------------------------------------------------------------------------
// uv_sphere_mesh_generator
// Emits one UV-sphere mesh element (vertex or triangle) per transfer.
// ---------------------------------------------------------------------------
// Each accepted item yields one result. A ring vertex passes through 16
// CORDIC iterations on latitude and longitude side by side, two registered
// multiply stages, and a handoff from datapath to controller before it can
// be transferred. Triangles and pole vertices skip the CORDIC and multiply
// stages. One item is in work at a time; a new item is accepted in the
// cycle the pending result is transferred.
module uv_sphere_mesh_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_restart,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_kind,
    output logic signed [usg_pkg::PosW-1:0] o_pos_x,
    output logic signed [usg_pkg::PosW-1:0] o_pos_y,
    output logic signed [usg_pkg::PosW-1:0] o_pos_z,
    output logic [usg_pkg::IdxW-1:0]        o_corner_a,
    output logic [usg_pkg::IdxW-1:0]        o_corner_b,
    output logic [usg_pkg::IdxW-1:0]        o_corner_c,
    output logic                            o_mesh_end,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import usg_pkg::*;

    logic [CntW-1:0] r_seg_count, r_ring_count;
    logic [RadW-1:0] r_radius;
    logic [AngW-1:0] r_ring_step, r_seg_step;
    t_cmd    cmd;
    t_status status;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count  <= CntW'(16);
            r_ring_count <= CntW'(16);
            r_radius     <= RadW'(256);
            r_ring_step  <= AngW'(2048);
            r_seg_step   <= AngW'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegSegCount:  r_seg_count  <= i_cfg_data[CntW-1:0];
                RegRingCount: r_ring_count <= i_cfg_data[CntW-1:0];
                RegRadius:    r_radius     <= i_cfg_data;
                RegRingStep:  r_ring_step  <= i_cfg_data;
                RegSegStep:   r_seg_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    usg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .i_restart,
        .o_cmd(cmd), .i_status(status)
    );

    usg_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_segment_count(r_seg_count), .i_ring_count(r_ring_count),
        .i_sphere_radius(r_radius), .i_ring_angle_step(r_ring_step),
        .i_segment_angle_step(r_seg_step),
        .o_kind, .o_pos_x, .o_pos_y, .o_pos_z,
        .o_corner_a, .o_corner_b, .o_corner_c, .o_mesh_end
    );
endmodule
